[rtl/mbe_pkg.sv]
`timescale 1ns / 1ps
// Shared types, widths, constants and helpers for the escape-time pixel core.
// Depends on nothing; everything else in rtl/ imports it.
package mbe_pkg;

  // fixed-point format: signed Q4.28
  localparam int FracBits = 28;
  localparam int ValW     = FracBits + 4;
  localparam int IntBits  = ValW - FracBits;
  localparam int ProdW    = 2 * ValW;

  // channel and register widths
  localparam int ColW    = 12;
  localparam int CfgW    = 13;
  localparam int LimitW  = 10;
  localparam int ColorW  = 8;
  localparam int CfgIdxW = 2;

  // coordinate arithmetic widths
  localparam int NumXW = 19;
  localparam int DenXW = 17;
  localparam int TW    = 14;
  localparam int PhW   = 27;
  localparam int PwW   = 26;
  localparam int NumW  = 33;
  localparam int DenW  = 31;
  localparam int RemW  = DenW + 1;

  // one divider cell per quotient bit
  localparam int CellCount = ValW;

  // coordinate mapping constants: cx from -2.3 to 1.0, span 3.3
  localparam int CxScale   = 33;
  localparam int CxOffset  = 23;
  localparam int DenXScale = 10;
  localparam int NumYScale = 33;
  localparam int DenYScale = 20;
  localparam int MinSide   = 2;

  // register map
  localparam logic [CfgIdxW-1:0] RegImageWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegImageHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] RegIterLimit   = 2'd2;

  localparam logic [CfgW-1:0]   WidthReset  = 13'd1433;
  localparam logic [CfgW-1:0]   HeightReset = 13'd1024;
  localparam logic [LimitW-1:0] LimitReset  = 10'd100;

  // saturation bounds and the escape radius squared
  localparam logic signed [ValW-1:0] VMax = {1'b0, {(ValW - 1){1'b1}}};
  localparam logic signed [ValW-1:0] VMin = {1'b1, {(ValW - 1){1'b0}}};
  localparam logic [ValW:0]          Four = (ValW + 1)'(1) << (FracBits + 2);

  // colour palette, packed as {red, green, blue}
  localparam int PaletteSize = 16;
  localparam int PalIdxW     = $clog2(PaletteSize);
  localparam logic [3*ColorW-1:0] Palette [PaletteSize] = '{
    24'h421E0F, 24'h19071A, 24'h09012F, 24'h040449,
    24'h000764, 24'h0C2C8A, 24'h1852B1, 24'h397DD1,
    24'h86B5E5, 24'hD3ECF8, 24'hF1E9BF, 24'hF8C95F,
    24'hFFAA00, 24'hCC8000, 24'h995700, 24'h6A3403
  };

  // divide request: signed numerator over positive denominator
  typedef struct packed {
    logic                   valid;
    logic                   sel_y;
    logic signed [NumW-1:0] num;
    logic [DenW-1:0]        den;
  } mbe_div_req_t;

  // divide result, already in Q4.28 and saturated
  typedef struct packed {
    logic                   valid;
    logic                   sel_y;
    logic signed [ValW-1:0] value;
  } mbe_div_res_t;

  // state carried from one divider cell to the next
  typedef struct packed {
    logic            valid;
    logic            sel_y;
    logic            neg;
    logic            ovf;
    logic [DenW-1:0] den;
    logic [RemW-1:0] rem;
    logic [ValW-1:0] qd;
  } mbe_cell_t;

  // clamp a wide signed value into the Q4.28 range
  function automatic logic signed [ValW-1:0] sat_val(input logic signed [ProdW-1:0] v);
    logic signed [ValW-1:0] res;
    if (v > ProdW'(VMax)) begin
      res = VMax;
    end else if (v < ProdW'(VMin)) begin
      res = VMin;
    end else begin
      res = v[ValW-1:0];
    end
    return res;
  endfunction

endpackage

[rtl/mbe_if.sv]
`timescale 1ns / 1ps
// Valid/ready channels of the escape-time pixel core: pixel in, colour out.
// Depends on mbe_pkg for the field widths.
interface mbe_pixel_if import mbe_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [ColW-1:0] pixel_column;
  logic [ColW-1:0] pixel_row;

  modport source (output valid, output pixel_column, output pixel_row, input ready);
  modport sink (input valid, input pixel_column, input pixel_row, output ready);
endinterface

interface mbe_result_if import mbe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ColorW-1:0] red;
  logic [ColorW-1:0] green;
  logic [ColorW-1:0] blue;
  logic [LimitW-1:0] escape_count;
  logic              inside_set;

  modport source (output valid, output red, output green, output blue,
                  output escape_count, output inside_set, input ready);
  modport sink (input valid, input red, input green, input blue,
                input escape_count, input inside_set, output ready);
endinterface

[rtl/mbe_div_cell.sv]
`timescale 1ns / 1ps
// One restoring-division step: shift in a dividend bit, trial subtract, emit a quotient bit.
// Depends on mbe_pkg for the cell struct.
module mbe_div_cell import mbe_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  mbe_cell_t cell_i,
  output mbe_cell_t cell_o
);

  logic [RemW-1:0] shifted;
  logic [RemW-1:0] den_ext;
  logic            ge;
  logic            valid_q;
  mbe_cell_t       data_q;
  mbe_cell_t       data_d;

  // trial subtract against the denominator
  always_comb begin
    shifted = {cell_i.rem[RemW-2:0], cell_i.qd[ValW-1]};
    den_ext = RemW'(cell_i.den);
    ge      = shifted >= den_ext;
    data_d  = cell_i;
    data_d.rem = ge ? shifted - den_ext : shifted;
    data_d.qd  = {cell_i.qd[ValW-2:0], ge};
  end

  // control bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cell_i.valid;
    end
  end

  // payload moves every cycle
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  always_comb begin
    cell_o       = data_q;
    cell_o.valid = valid_q;
  end

endmodule

[rtl/mbe_div_chain.sv]
`timescale 1ns / 1ps
// Pipelined fixed-point divider: a row of mbe_div_cell stages, one quotient bit each.
// Depends on mbe_pkg and mbe_div_cell; returns floor(num * 2^FracBits / den) saturated.
module mbe_div_chain import mbe_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  mbe_div_req_t req_i,
  output mbe_div_res_t res_o
);

  logic [NumW-1:0]         abs_num;
  logic [ValW-1:0]         mag;
  mbe_cell_t               link [CellCount+1];
  mbe_cell_t               tail;
  logic                    lost;
  logic [ValW:0]           mag_r;
  logic signed [ProdW-1:0] wide;
  logic signed [ValW-1:0]  value_d;
  logic                    res_valid_q;
  logic                    res_sel_q;
  logic signed [ValW-1:0]  res_value_q;

  // front end: sign and magnitude, integer-part overflow, first remainder
  always_comb begin
    abs_num = req_i.num[NumW-1] ? NumW'(-req_i.num) : NumW'(req_i.num);
    mag     = abs_num[ValW-1:0];
    link[0].valid = req_i.valid;
    link[0].sel_y = req_i.sel_y;
    link[0].neg   = req_i.num[NumW-1];
    link[0].ovf   = RemW'(mag[ValW-1:IntBits]) >= RemW'(req_i.den);
    link[0].den   = req_i.den;
    link[0].rem   = RemW'(mag[ValW-1:IntBits]);
    link[0].qd    = {mag[IntBits-1:0], FracBits'(0)};
  end

  // the cell row
  for (genvar k = 0; k < CellCount; k++) begin : g_cell
    mbe_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cell_i (link[k]),
      .cell_o (link[k+1])
    );
  end

  // back end: round toward minus infinity for negatives, then saturate
  always_comb begin
    tail  = link[CellCount];
    lost  = tail.rem != '0;
    mag_r = {1'b0, tail.qd} + (ValW + 1)'(tail.neg & lost);
    wide  = tail.neg ? -ProdW'(mag_r) : ProdW'(mag_r);
    if (tail.ovf) begin
      value_d = tail.neg ? VMin : VMax;
    end else begin
      value_d = sat_val(wide);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= tail.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    res_sel_q   <= tail.sel_y;
    res_value_q <= value_d;
  end

  assign res_o.valid = res_valid_q;
  assign res_o.sel_y = res_sel_q;
  assign res_o.value = res_value_q;

endmodule

[rtl/mandelbrot_escape_time_pixel_core.sv]
`timescale 1ns / 1ps
// Escape-time pixel core: one pixel in, iteration count and palette colour out.
// Latency grows with the number of steps before escape, or with the limit L when it is hit;
// the next pixel is accepted in the cycle after the result loads.
// A 32-cell divider row computes cx and cy; each iteration runs a multiply step, then an update step.
// Result register lets the next pixel start while a colour waits for transfer.
// Reset (async, active low) sets width 1433, height 1024, limit 100 and empties the pipeline.
module mandelbrot_escape_time_pixel_core import mbe_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  mbe_pixel_if.sink          pixel_i,
  mbe_result_if.source       color_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_PROD, S_FEEDX, S_FEEDY, S_WAIT, S_ITM, S_ITU, S_FIN
  } state_e;

  state_e                  state_q;
  logic [CfgW-1:0]         width_q;
  logic [CfgW-1:0]         height_q;
  logic [LimitW-1:0]       limit_q;
  logic [LimitW-1:0]       it_q;
  logic                    inside_q;
  logic                    out_valid_q;

  logic [ColW-1:0]         col_q;
  logic [ColW-1:0]         row_q;
  logic [CfgW-1:0]         w_eff;
  logic [CfgW-1:0]         h_eff;
  logic [CfgW-1:0]         wm1;
  logic [CfgW-1:0]         hm1;
  logic signed [TW-1:0]    t;
  logic signed [PhW-1:0]   h_s;
  logic signed [PhW-1:0]   t_s;
  logic signed [PhW-1:0]   ph_q;
  logic [PwW-1:0]          pw_q;
  logic signed [NumXW-1:0] numx_q;
  logic [DenXW-1:0]        denx_q;
  logic signed [NumW-1:0]  numy_q;
  logic [DenW-1:0]         deny_q;

  mbe_div_req_t            div_req;
  mbe_div_res_t            div_res;
  logic signed [ValW-1:0]  cx_q;
  logic signed [ValW-1:0]  cy_q;

  logic signed [ValW-1:0]  x_q;
  logic signed [ValW-1:0]  y_q;
  logic signed [ProdW-1:0] p_xx_q;
  logic signed [ProdW-1:0] p_yy_q;
  logic signed [ProdW-1:0] p_xy_q;
  logic signed [ValW-1:0]  x2;
  logic signed [ValW-1:0]  y2;
  logic signed [ValW-1:0]  xy;
  logic signed [ValW-1:0]  xy2;
  logic [ValW:0]           mag_sum;
  logic                    escape;
  logic signed [ValW-1:0]  x_next;
  logic signed [ValW-1:0]  y_next;

  logic                    load;
  logic [PalIdxW-1:0]      pal_idx;
  logic [3*ColorW-1:0]     rgb;
  logic [ColorW-1:0]       red_q;
  logic [ColorW-1:0]       green_q;
  logic [ColorW-1:0]       blue_q;
  logic [LimitW-1:0]       esc_q;
  logic                    inside_out_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
      limit_q  <= LimitReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegImageWidth:  width_q  <= cfg_data_i;
        RegImageHeight: height_q <= cfg_data_i;
        RegIterLimit:   limit_q  <= cfg_data_i[LimitW-1:0];
        default: ;
      endcase
    end
  end

  // image sides, small values lifted to the minimum
  always_comb begin
    w_eff = (width_q < CfgW'(MinSide)) ? CfgW'(MinSide) : width_q;
    h_eff = (height_q < CfgW'(MinSide)) ? CfgW'(MinSide) : height_q;
    wm1   = w_eff - CfgW'(1);
    hm1   = h_eff - CfgW'(1);
    t     = signed'({1'b0, hm1}) - signed'({1'b0, row_q, 1'b0});
    h_s   = PhW'(signed'({1'b0, h_eff}));
    t_s   = PhW'(t);
  end

  // divider requests: cx first, cy in the following cycle
  always_comb begin
    div_req.valid = (state_q == S_FEEDX) || (state_q == S_FEEDY);
    div_req.sel_y = state_q == S_FEEDY;
    div_req.num   = (state_q == S_FEEDY) ? numy_q : NumW'(numx_q);
    div_req.den   = (state_q == S_FEEDY) ? deny_q : DenW'(denx_q);
  end

  mbe_div_chain u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .res_o  (div_res)
  );

  // escape test and next z from the registered products
  always_comb begin
    x2      = sat_val(p_xx_q >>> FracBits);
    y2      = sat_val(p_yy_q >>> FracBits);
    xy      = sat_val(p_xy_q >>> FracBits);
    mag_sum = (ValW + 1)'(unsigned'(x2)) + (ValW + 1)'(unsigned'(y2));
    escape  = mag_sum > Four;
    x_next  = sat_val(ProdW'(x2) - ProdW'(y2) + ProdW'(cx_q));
    xy2     = sat_val({{(ProdW - ValW - 1){xy[ValW-1]}}, xy, 1'b0});
    y_next  = sat_val(ProdW'(xy2) + ProdW'(cy_q));
  end

  // colour lookup and result register load
  always_comb begin
    load    = (state_q == S_FIN) && (!out_valid_q || color_o.ready);
    pal_idx = PalIdxW'(it_q % PaletteSize);
    rgb     = inside_q ? '0 : Palette[pal_idx];
  end

  // control: sequencer, iteration count and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      it_q        <= '0;
      inside_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (pixel_i.valid) begin
            state_q <= S_PROD;
          end
        end
        S_PROD:  state_q <= S_FEEDX;
        S_FEEDX: state_q <= S_FEEDY;
        S_FEEDY: state_q <= S_WAIT;
        S_WAIT: begin
          if (div_res.valid && div_res.sel_y) begin
            it_q    <= '0;
            state_q <= S_ITM;
          end
        end
        S_ITM: begin
          if (it_q >= limit_q) begin
            inside_q <= 1'b1;
            state_q  <= S_FIN;
          end else begin
            state_q <= S_ITU;
          end
        end
        S_ITU: begin
          if (escape) begin
            inside_q <= 1'b0;
            state_q  <= S_FIN;
          end else begin
            it_q    <= it_q + LimitW'(1);
            state_q <= S_ITM;
          end
        end
        S_FIN: begin
          if (load) begin
            state_q <= S_IDLE;
          end
        end
      endcase
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (color_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && pixel_i.valid) begin
      col_q <= pixel_i.pixel_column;
      row_q <= pixel_i.pixel_row;
    end
    // coordinate numerators and denominators
    if (state_q == S_PROD) begin
      ph_q   <= h_s * t_s;
      pw_q   <= PwW'(w_eff) * PwW'(hm1);
      numx_q <= signed'(NumXW'(col_q) * NumXW'(CxScale) - NumXW'(wm1) * NumXW'(CxOffset));
      denx_q <= DenXW'(wm1) * DenXW'(DenXScale);
    end
    if (state_q == S_FEEDX) begin
      numy_q <= NumW'(ph_q) * NumW'(NumYScale);
      deny_q <= DenW'(pw_q) * DenW'(DenYScale);
    end
    // c from the divider
    if (div_res.valid) begin
      if (div_res.sel_y) begin
        cy_q <= div_res.value;
      end else begin
        cx_q <= div_res.value;
      end
    end
    // z iteration
    if (state_q == S_WAIT && div_res.valid && div_res.sel_y) begin
      x_q <= '0;
      y_q <= '0;
    end else if (state_q == S_ITU && !escape) begin
      x_q <= x_next;
      y_q <= y_next;
    end
    if (state_q == S_ITM) begin
      p_xx_q <= ProdW'(x_q) * ProdW'(x_q);
      p_yy_q <= ProdW'(y_q) * ProdW'(y_q);
      p_xy_q <= ProdW'(x_q) * ProdW'(y_q);
    end
    // result register
    if (load) begin
      red_q        <= rgb[3*ColorW-1:2*ColorW];
      green_q      <= rgb[2*ColorW-1:ColorW];
      blue_q       <= rgb[ColorW-1:0];
      esc_q        <= it_q;
      inside_out_q <= inside_q;
    end
  end

  assign pixel_i.ready        = state_q == S_IDLE;
  assign color_o.valid        = out_valid_q;
  assign color_o.red          = red_q;
  assign color_o.green        = green_q;
  assign color_o.blue         = blue_q;
  assign color_o.escape_count = esc_q;
  assign color_o.inside_set   = inside_out_q;

`ifndef NO_ASSERTIONS
  // a new result only comes out of the finish step
  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(color_o.valid) |-> $past(state_q == S_FIN))
    else $error("result valid rose outside finish step");

  // an update step never runs at or past the limit
  a_it_below_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ITU) |-> (it_q < limit_q))
    else $error("iteration count reached limit in update step");

  // divider results only arrive while waiting for them
  a_div_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_res.valid |-> (state_q == S_WAIT))
    else $error("divider result outside wait state");
`endif

endmodule
